[rtl/core/rqrr_pkg.sv]
`timescale 1ns / 1ps

package rqrr_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    localparam int CMD_W    = 3;
    localparam int TID_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SCHEDULE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_READY = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TID_W-1:0]    thread_id;
        logic                ready;
        logic [COUNT_W-1:0]  count;
        logic                empty;
    } result_t;

endpackage

[rtl/core/rqrr_mem.sv]
`timescale 1ns / 1ps

module rqrr_mem #(
    parameter int DEPTH = rqrr_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = rqrr_pkg::ID_BITS_DEF + 1,
    parameter int AW    = $clog2(rqrr_pkg::QUEUE_DEPTH_DEF)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/rqrr_outreg.sv]
`timescale 1ns / 1ps

module rqrr_outreg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rqrr_pkg::result_t res_in,
    output logic              out_free,
    output logic              res_valid,
    input  logic              res_ready,
    output rqrr_pkg::result_t res_out
);

    logic              valid_reg;
    rqrr_pkg::result_t data_reg;

    assign out_free  = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign res_out   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

endmodule

[rtl/core/rqrr_ctrl.sv]
`timescale 1ns / 1ps

module rqrr_ctrl #(
    parameter int QUEUE_DEPTH = rqrr_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = rqrr_pkg::ID_BITS_DEF,
    parameter int AW          = $clog2(QUEUE_DEPTH),
    parameter int EW          = ID_BITS + 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rqrr_pkg::CMD_W-1:0] cmd,
    input  logic [rqrr_pkg::TID_W-1:0] thread_id,
    input  logic                       ready_in,
    output logic                       mem_wr_en,
    output logic [AW-1:0]              mem_wr_addr,
    output logic [EW-1:0]              mem_wr_data,
    output logic                       mem_rd_en,
    output logic [AW-1:0]              mem_rd_addr,
    input  logic [EW-1:0]              mem_rd_data,
    input  logic                       out_free,
    output logic                       load,
    output rqrr_pkg::result_t          res
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = rqrr_pkg::TID_W;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FINISH} state_t;

    state_t                           state_reg, state_next;
    logic [AW-1:0]                    head_reg, head_next;
    logic [AW-1:0]                    tail_reg, tail_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [rqrr_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic [ID_BITS-1:0]               tid_reg, tid_next;
    logic                             rdy_reg, rdy_next;
    logic [AW-1:0]                    rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]                    pos_reg, pos_next;
    logic [CW-1:0]                    left_reg, left_next;
    logic [rqrr_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [TW-1:0]                    oid_reg, oid_next;
    logic                             ordy_reg, ordy_next;

    logic [ID_BITS+TW-1:0]            tid_ext;
    logic [ID_BITS-1:0]               tid_in;
    logic [ID_BITS-1:0]               rd_id;
    logic                             rd_rdy;
    logic [ID_BITS+TW-1:0]            rd_id_ext;
    logic [CW+rqrr_pkg::COUNT_W-1:0]  count_ext;
    logic                             full;
    logic                             hit;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
        return (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    assign tid_ext   = {{ID_BITS{1'b0}}, thread_id};
    assign tid_in    = tid_ext[ID_BITS-1:0];
    assign rd_id     = mem_rd_data[EW-1:1];
    assign rd_rdy    = mem_rd_data[0];
    assign rd_id_ext = {{TW{1'b0}}, rd_id};
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign in_ready  = (state_reg == ST_IDLE);
    assign load      = (state_reg == ST_FINISH) && out_free;

    assign count_ext     = {{rqrr_pkg::COUNT_W{1'b0}}, count_reg};
    assign res.status    = status_reg;
    assign res.thread_id = oid_reg;
    assign res.ready     = ordy_reg;
    assign res.count     = count_ext[rqrr_pkg::COUNT_W-1:0];
    assign res.empty     = (count_reg == '0);

    // Whether the entry now on the read port ends the walk.
    always_comb
    begin
        unique case (cmd_reg)
            rqrr_pkg::CMD_DEQUEUE:  hit = 1'b1;
            rqrr_pkg::CMD_SCHEDULE: hit = rd_rdy;
            default:                hit = (rd_id == tid_reg);
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        cmd_next    = cmd_reg;
        tid_next    = tid_reg;
        rdy_next    = rdy_reg;
        rd_ptr_next = rd_ptr_reg;
        pos_next    = pos_reg;
        left_next   = left_reg;
        status_next = status_reg;
        oid_next    = oid_reg;
        ordy_next   = ordy_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = tail_reg;
        mem_wr_data = {tid_in, ready_in};
        mem_rd_en   = 1'b0;
        mem_rd_addr = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = cmd;
                    tid_next    = tid_in;
                    rdy_next    = ready_in;
                    status_next = rqrr_pkg::STATUS_OK;
                    oid_next    = '0;
                    ordy_next   = 1'b0;
                    state_next  = ST_FINISH;
                    unique case (cmd) inside
                        rqrr_pkg::CMD_ENQUEUE:
                        begin
                            if (full)
                            begin
                                status_next = rqrr_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_wr_en  = 1'b1;
                                tail_next  = ring_next(tail_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        rqrr_pkg::CMD_DEQUEUE, rqrr_pkg::CMD_SCHEDULE,
                        rqrr_pkg::CMD_LOOKUP, rqrr_pkg::CMD_SET_READY:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = rqrr_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                rd_ptr_next = ring_next(head_reg);
                                pos_next    = head_reg;
                                left_next   = count_reg - 1'b1;
                                state_next  = ST_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                if (hit)
                begin
                    oid_next   = rd_id_ext[TW-1:0];
                    ordy_next  = rd_rdy;
                    state_next = ST_FINISH;
                    if (cmd_reg == rqrr_pkg::CMD_DEQUEUE || cmd_reg == rqrr_pkg::CMD_SCHEDULE)
                    begin
                        head_next  = ring_next(head_reg);
                        count_next = count_reg - 1'b1;
                    end
                    if (cmd_reg == rqrr_pkg::CMD_SET_READY)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = pos_reg;
                        mem_wr_data = {rd_id, rdy_reg};
                        ordy_next   = rdy_reg;
                    end
                end
                else
                begin
                    // A skipped entry of a schedule is copied from the head to the tail.
                    if (cmd_reg == rqrr_pkg::CMD_SCHEDULE)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data;
                        head_next   = ring_next(head_reg);
                        tail_next   = ring_next(tail_reg);
                    end
                    if (left_reg == '0)
                    begin
                        status_next = rqrr_pkg::STATUS_EMPTY;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = rd_ptr_reg;
                        rd_ptr_next = ring_next(rd_ptr_reg);
                        pos_next    = rd_ptr_reg;
                        left_next   = left_reg - 1'b1;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            pos_reg    <= '0;
            left_reg   <= '0;
            cmd_reg    <= rqrr_pkg::CMD_ENQUEUE;
            status_reg <= rqrr_pkg::STATUS_OK;
            oid_reg    <= '0;
            ordy_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            pos_reg    <= pos_next;
            left_reg   <= left_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
            oid_reg    <= oid_next;
            ordy_reg   <= ordy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg <= tid_next;
        rdy_reg <= rdy_next;
    end

endmodule

[rtl/core/ready_queue_round_robin_picker.sv]
`timescale 1ns / 1ps

// Round-robin ready queue: a ring of thread identifiers, each with a ready flag.
// The input channel (in_valid/in_ready) carries one command item: enqueue,
// dequeue, schedule, lookup or set-ready. Each item yields exactly one result
// item on the output channel (res_valid/res_ready) with status, identifier,
// ready flag and the count held after the command.
// Commands run one at a time. Enqueue and unknown commands go from acceptance
// straight to the result state; dequeue first reads the head entry. Schedule,
// lookup and set-ready walk the ring through the single read port of the entry
// memory, one entry per cycle; the next item is taken in the cycle after the
// result is loaded.
// Reset empties the queue (head, tail and count go to zero) and drops any
// pending result; entry storage is not cleared. When the receiver stalls, the
// result waits in the output register and the block holds the finished
// command until that register frees up.
module ready_queue_round_robin_picker #(
    parameter int QUEUE_DEPTH = rqrr_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = rqrr_pkg::ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rqrr_pkg::CMD_W-1:0]    cmd,
    input  logic [rqrr_pkg::TID_W-1:0]    thread_id,
    input  logic                          ready_in,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [rqrr_pkg::STATUS_W-1:0] status,
    output logic [rqrr_pkg::TID_W-1:0]    out_thread_id,
    output logic                          out_ready,
    output logic [rqrr_pkg::COUNT_W-1:0]  queue_count,
    output logic                          queue_empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int EW = ID_BITS + 1;

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [EW-1:0]     mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [EW-1:0]     mem_rd_data;
    logic              out_free;
    logic              load;
    rqrr_pkg::result_t res_int;
    rqrr_pkg::result_t res_out;

    rqrr_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .AW          (AW),
        .EW          (EW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .thread_id   (thread_id),
        .ready_in    (ready_in),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .out_free    (out_free),
        .load        (load),
        .res         (res_int)
    );

    rqrr_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rqrr_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res_in    (res_int),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_out   (res_out)
    );

    assign status        = res_out.status;
    assign out_thread_id = res_out.thread_id;
    assign out_ready     = res_out.ready;
    assign queue_count   = res_out.count;
    assign queue_empty   = res_out.empty;

endmodule

[rtl/core/rqrr_checker.sv]
`timescale 1ns / 1ps

module rqrr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [rqrr_pkg::STATUS_W-1:0] status,
    input logic [rqrr_pkg::TID_W-1:0]    out_thread_id,
    input logic                          out_ready,
    input logic [rqrr_pkg::COUNT_W-1:0]  queue_count,
    input logic                          queue_empty
);

    // A result that is not taken holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status)
            && $stable(out_thread_id) && $stable(out_ready) && $stable(queue_count))
        else $error("stalled result changed");

    // Commands are worked one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while a command is in progress");

    // A rejected enqueue means the queue holds entries and returns nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == rqrr_pkg::STATUS_FULL |->
            !queue_empty && out_thread_id == '0 && !out_ready)
        else $error("full status with bad payload");

    // Empty or not-found results carry no identifier.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == rqrr_pkg::STATUS_EMPTY |->
            out_thread_id == '0 && !out_ready)
        else $error("empty status with identifier");

endmodule

bind ready_queue_round_robin_picker rqrr_checker u_rqrr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .status        (status),
    .out_thread_id (out_thread_id),
    .out_ready     (out_ready),
    .queue_count   (queue_count),
    .queue_empty   (queue_empty)
);

[tb/ready_queue_round_robin_picker_test.sv]
`timescale 1ns / 1ps

module ready_queue_round_robin_picker_test;

    localparam int DEPTH        = rqrr_pkg::QUEUE_DEPTH_DEF;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int CMDW         = rqrr_pkg::CMD_W;
    localparam int TW           = rqrr_pkg::TID_W;
    localparam int CNTW         = rqrr_pkg::COUNT_W;

    // Command codes the block ignores.
    localparam logic [CMDW-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMDW-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMDW-1:0] CMD_RSVD_7 = 3'd7;

    typedef struct {
        logic [TW-1:0] id;
        logic          rdy;
    } slot_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic [CMDW-1:0]               cmd       = rqrr_pkg::CMD_ENQUEUE;
    logic [TW-1:0]                 thread_id = '0;
    logic                          ready_in  = 1'b0;
    logic                          res_valid;
    logic                          res_ready = 1'b0;
    logic [rqrr_pkg::STATUS_W-1:0] status;
    logic [TW-1:0]                 out_thread_id;
    logic                          out_ready;
    logic [CNTW-1:0]               queue_count;
    logic                          queue_empty;

    slot_t             ring_q[$];
    rqrr_pkg::result_t expected_q[$];
    rqrr_pkg::result_t want;
    int                errors = 0;
    int                checked = 0;
    int                cmd_seen[8];
    bit                idle_on = 1'b0;
    int                res_stall_left = 0;
    int                quiet_cycles = 0;

    ready_queue_round_robin_picker DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .thread_id    (thread_id),
        .ready_in     (ready_in),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .status       (status),
        .out_thread_id(out_thread_id),
        .out_ready    (out_ready),
        .queue_count  (queue_count),
        .queue_empty  (queue_empty)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Applies one command to the queue copy and returns the result it must give.
    function automatic rqrr_pkg::result_t apply_command(logic [CMDW-1:0] c, logic [TW-1:0] tid,
                                                        logic rdy);
        rqrr_pkg::result_t r;
        slot_t             s;
        int                n;
        bit                got;
        r = '0;
        r.status = rqrr_pkg::STATUS_OK;
        got = 1'b0;
        case (c)
            rqrr_pkg::CMD_ENQUEUE:
            begin
                if (ring_q.size() >= DEPTH)
                    r.status = rqrr_pkg::STATUS_FULL;
                else
                begin
                    s.id  = tid;
                    s.rdy = rdy;
                    ring_q.push_back(s);
                end
            end
            rqrr_pkg::CMD_DEQUEUE:
            begin
                if (ring_q.size() == 0)
                    r.status = rqrr_pkg::STATUS_EMPTY;
                else
                begin
                    s = ring_q.pop_front();
                    r.thread_id = s.id;
                    r.ready     = s.rdy;
                end
            end
            rqrr_pkg::CMD_SCHEDULE:
            begin
                // Entries that are not ready go to the back in order; the first
                // ready one leaves the queue.
                n = ring_q.size();
                for (int i = 0; i < n && !got; i++)
                begin
                    s = ring_q.pop_front();
                    if (s.rdy)
                    begin
                        got = 1'b1;
                        r.thread_id = s.id;
                        r.ready     = 1'b1;
                    end
                    else
                        ring_q.push_back(s);
                end
                if (!got)
                    r.status = rqrr_pkg::STATUS_EMPTY;
            end
            rqrr_pkg::CMD_LOOKUP, rqrr_pkg::CMD_SET_READY:
            begin
                for (int i = 0; i < ring_q.size() && !got; i++)
                begin
                    if (ring_q[i].id == tid)
                    begin
                        if (c == rqrr_pkg::CMD_SET_READY)
                            ring_q[i].rdy = rdy;
                        r.thread_id = ring_q[i].id;
                        r.ready     = ring_q[i].rdy;
                        got = 1'b1;
                    end
                end
                if (!got)
                    r.status = rqrr_pkg::STATUS_EMPTY;
            end
            default:
            begin
            end
        endcase
        r.count = CNTW'(ring_q.size());
        r.empty = (ring_q.size() == 0);
        return r;
    endfunction

    function automatic void compare_field(string field, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
            errors++;
        end
    endfunction

    // Input and output monitors share one block so that their order is fixed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_q.push_back(apply_command(cmd, thread_id, ready_in));
                cmd_seen[cmd]++;
            end
            if (res_valid && res_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding, status %0d id %0d",
                             $time, status, out_thread_id);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("status", 8'(want.status), 8'(status));
                    compare_field("out_thread_id", 8'(want.thread_id), 8'(out_thread_id));
                    compare_field("out_ready", 8'(want.ready), 8'(out_ready));
                    compare_field("queue_count", 8'(want.count), 8'(queue_count));
                    compare_field("queue_empty", 8'(want.empty), 8'(queue_empty));
                    checked++;
                end
            end
            if ((in_valid && in_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("ready_queue_round_robin_picker_test: FAIL");
                $finish;
            end
        end
    end

    // Receiver side: random stalls while idling is enabled.
    always @(posedge clk)
    begin
        if (!idle_on)
            res_ready <= 1'b1;
        else
        begin
            if (res_stall_left == 0)
                res_stall_left = pick_gap();
            if (res_stall_left > 0)
            begin
                res_ready <= 1'b0;
                res_stall_left--;
            end
            else
                res_ready <= 1'b1;
        end
    end

    task automatic send_cmd(logic [CMDW-1:0] c, logic [TW-1:0] tid, logic rdy);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        thread_id <= tid;
        ready_in  <= rdy;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic test_empty_commands();
        send_cmd(rqrr_pkg::CMD_DEQUEUE, 8'd0, 1'b0);
        send_cmd(rqrr_pkg::CMD_SCHEDULE, 8'd0, 1'b0);
        send_cmd(rqrr_pkg::CMD_LOOKUP, 8'd255, 1'b1);
        send_cmd(rqrr_pkg::CMD_SET_READY, 8'd0, 1'b1);
        send_cmd(CMD_RSVD_7, 8'd255, 1'b1);
    endtask

    // Fills the ring with entries that are not ready, two of them sharing an
    // identifier, then tries one enqueue too many.
    task automatic test_fill_to_overflow();
        logic [TW-1:0] tid;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                tid = 8'd0;
            else if (i == DEPTH - 1)
                tid = 8'd255;
            else if (i == 5 || i == 11)
                tid = 8'h3C;
            else
                tid = TW'(i * 17);
            send_cmd(rqrr_pkg::CMD_ENQUEUE, tid, 1'b0);
        end
        send_cmd(rqrr_pkg::CMD_ENQUEUE, 8'hAA, 1'b1);
    endtask

    task automatic test_schedule_rotation();
        send_cmd(rqrr_pkg::CMD_SCHEDULE, 8'd0, 1'b0);
        send_cmd(rqrr_pkg::CMD_LOOKUP, 8'h3C, 1'b0);
        send_cmd(rqrr_pkg::CMD_SET_READY, 8'h3C, 1'b1);
        send_cmd(rqrr_pkg::CMD_SCHEDULE, 8'd0, 1'b0);
        send_cmd(rqrr_pkg::CMD_LOOKUP, 8'h3C, 1'b0);
    endtask

    // Weighted mix of commands; identifiers are often taken from the queue so
    // that lookups and set-ready commands find their entries.
    task automatic test_random_traffic(int items, int w_enq, int w_deq, int w_sched,
                                       int w_look, int w_set);
        int              total;
        int              r;
        logic [CMDW-1:0] c;
        logic [TW-1:0]   tid;
        logic            rdy;
        total = w_enq + w_deq + w_sched + w_look + w_set;
        for (int n = 0; n < items; n++)
        begin
            r = $urandom_range(0, total - 1);
            if ($urandom_range(0, 99) < 2)
                c = CMDW'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
            else if (r < w_enq)
                c = rqrr_pkg::CMD_ENQUEUE;
            else if (r < w_enq + w_deq)
                c = rqrr_pkg::CMD_DEQUEUE;
            else if (r < w_enq + w_deq + w_sched)
                c = rqrr_pkg::CMD_SCHEDULE;
            else if (r < w_enq + w_deq + w_sched + w_look)
                c = rqrr_pkg::CMD_LOOKUP;
            else
                c = rqrr_pkg::CMD_SET_READY;
            r = $urandom_range(0, 99);
            if (ring_q.size() > 0 && r < 45)
                tid = ring_q[$urandom_range(0, ring_q.size() - 1)].id;
            else if (r < 70)
                tid = TW'($urandom_range(0, 15));
            else
                tid = TW'($urandom_range(0, 255));
            rdy = ($urandom_range(0, 99) < 35);
            send_cmd(c, tid, rdy);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;
        test_empty_commands();
        test_fill_to_overflow();
        test_schedule_rotation();
        test_random_traffic(600, 30, 15, 20, 20, 15);
        idle_on = 1'b0;
        test_random_traffic(300, 55, 5, 15, 15, 10);
        idle_on = 1'b1;
        test_random_traffic(300, 10, 35, 30, 15, 10);
        test_random_traffic(600, 30, 20, 25, 15, 10);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d enqueue, %0d dequeue, %0d schedule, %0d lookup, %0d set-ready",
                 cmd_seen[rqrr_pkg::CMD_ENQUEUE], cmd_seen[rqrr_pkg::CMD_DEQUEUE],
                 cmd_seen[rqrr_pkg::CMD_SCHEDULE], cmd_seen[rqrr_pkg::CMD_LOOKUP],
                 cmd_seen[rqrr_pkg::CMD_SET_READY]);
        $display("and %0d reserved commands; %0d results compared under random stalls.",
                 cmd_seen[CMD_RSVD_5] + cmd_seen[CMD_RSVD_6] + cmd_seen[CMD_RSVD_7], checked);
        if (errors == 0)
            $display("ready_queue_round_robin_picker_test: PASS");
        else
            $display("ready_queue_round_robin_picker_test: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rqrr_pkg.sv
rtl/core/rqrr_mem.sv
rtl/core/rqrr_outreg.sv
rtl/core/rqrr_ctrl.sv
rtl/core/ready_queue_round_robin_picker.sv
rtl/core/rqrr_checker.sv
tb/ready_queue_round_robin_picker_test.sv
